/* hdl/sjf_pkg.sv */
package sjf_pkg;

    localparam int DUR_W        = 16;
    localparam int JOB_W        = 7;
    localparam int FIN_W        = 22;
    localparam int RUN_W        = 23;
    localparam int SUM_W        = 28;
    localparam int MAX_JOBS_DEF = 64;

    // one slot of the sorted chain
    typedef struct packed {
        logic             valid;
        logic [DUR_W-1:0] dur;
        logic [JOB_W-1:0] job;
    } sjf_cell_t;

    // chain-wide command, same for every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } sjf_ctl_t;

endpackage

/* hdl/shortest_job_first_scheduler.sv */
// After the request flagged s_tlast is accepted, drain_reg is set, and the first result of
//   the batch is then registered in the output register and shows on m_tdata.
// Throughput: one job request per cycle while filling; while draining, one result per cycle
//   unless m_tready holds off the output; the input stalls during drain.
// Reset: aresetn synchronous, active low; empties the chain and clears all counters.
module shortest_job_first_scheduler
    import sjf_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] duration
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [6:0] job_number, [22:7] job_duration,
                                   // [44:23] finish_time, [72:45] total_finish, pad
    output logic [0:0]  m_tuser,   // [0] dropped
    output logic        m_tlast    // end_of_batch
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    // the chain: cell 0 holds the shortest job
    sjf_cell_t           cells [MAX_JOBS];
    logic [MAX_JOBS-1:0] gt;
    logic [MAX_JOBS-1:0] cell_valid;
    sjf_ctl_t            ctl;

    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [RUN_W-1:0] run_reg, run_next, run_sum;
    logic [SUM_W-1:0] fsum_reg, fsum_next, fsum_sum;

    logic             m_valid_reg, m_valid_next;
    logic [JOB_W-1:0] o_job_reg;
    logic [DUR_W-1:0] o_dur_reg;
    logic [FIN_W-1:0] o_fin_reg;
    logic [SUM_W-1:0] o_tot_reg;
    logic             o_drop_reg;
    logic             o_last_reg;

    logic             s_acc;
    logic             full;
    logic             pop;
    logic             last_pop;
    logic [JOB_W-1:0] new_job;

    // head sentinel: "valid" so cell 0 takes a job into an empty chain
    localparam sjf_cell_t HEAD = '{valid: 1'b1, dur: '0, job: '0};
    localparam sjf_cell_t TAIL = '{valid: 1'b0, dur: '0, job: '0};

    assign s_tready = !drain_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(MAX_JOBS));
    assign new_job  = JOB_W'(CNT_W'(count_reg + 1'b1));

    // drain moves one result a cycle into the output register while it is empty or taken
    assign pop      = drain_reg && (!m_valid_reg || m_tready);
    assign last_pop = pop && !cells[1].valid;

    assign ctl.insert = s_acc && !full;
    assign ctl.shift  = pop;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_JOBS; gi++) begin : g_chain
            sjf_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .new_dur   (s_tdata),
                .new_job   (new_job),
                .prev_cell ((gi == 0) ? HEAD : cells[(gi == 0) ? 0 : gi - 1]),
                .prev_gt   ((gi == 0) ? 1'b0 : gt[(gi == 0) ? 0 : gi - 1]),
                .next_cell ((gi == MAX_JOBS - 1) ? TAIL
                                                 : cells[(gi == MAX_JOBS - 1) ? gi : gi + 1]),
                .cell_out  (cells[gi]),
                .gt_out    (gt[gi])
            );
            assign cell_valid[gi] = cells[gi].valid;
        end
    endgenerate

    // completion times accumulate in scheduled order
    assign run_sum  = run_reg + RUN_W'(cells[0].dur);
    assign fsum_sum = fsum_reg + SUM_W'(run_sum);

    always_comb begin
        drain_next   = drain_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        run_next     = run_reg;
        fsum_next    = fsum_reg;
        m_valid_next = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.insert) begin
            count_next = count_reg + 1'b1;
        end
        if (s_acc && full) begin
            ovf_next = 1'b1;    // job beyond capacity is discarded
        end
        if (s_acc && s_tlast) begin
            drain_next = 1'b1;
        end
        if (pop) begin
            m_valid_next = 1'b1;
            run_next     = run_sum;
            fsum_next    = fsum_sum;
        end
        if (last_pop) begin
            // batch done: back to the reset state
            drain_next = 1'b0;
            count_next = '0;
            ovf_next   = 1'b0;
            run_next   = '0;
            fsum_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg   <= 1'b0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            run_reg     <= '0;
            fsum_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            drain_reg   <= drain_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            run_reg     <= run_next;
            fsum_reg    <= fsum_next;
            m_valid_reg <= m_valid_next;
        end
        if (pop) begin
            o_job_reg  <= cells[0].job;
            o_dur_reg  <= cells[0].dur;
            o_fin_reg  <= FIN_W'(run_sum);
            o_tot_reg  <= last_pop ? fsum_sum : '0;
            o_drop_reg <= ovf_reg;
            o_last_reg <= last_pop;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, o_tot_reg, o_fin_reg, o_dur_reg, o_job_reg};
    assign m_tuser  = o_drop_reg;
    assign m_tlast  = o_last_reg;

`ifndef SYNTHESIS
    // occupied slots always form a prefix of the chain
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("chain has a hole");

    // outside drain the fill count matches the occupied slots
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !drain_reg |-> (count_reg == CNT_W'($countones(cell_valid))))
        else $error("job count out of step with chain");

    // head pair stays in ascending order
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        cells[1].valid |-> (cells[0].dur <= cells[1].dur))
        else $error("chain head out of order");

    // last result of a batch leaves the block idle and empty
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        last_pop |=> (!drain_reg && count_reg == '0 && cell_valid == '0 && m_tlast))
        else $error("batch did not close cleanly");
`endif

endmodule

/* hdl/sjf_cell.sv */
module sjf_cell
    import sjf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  sjf_ctl_t         ctl,
    input  logic [DUR_W-1:0] new_dur,
    input  logic [JOB_W-1:0] new_job,
    input  sjf_cell_t        prev_cell,
    input  logic             prev_gt,
    input  sjf_cell_t        next_cell,
    output sjf_cell_t        cell_out,
    output logic             gt_out
);

    logic             valid_reg, valid_next;
    logic [DUR_W-1:0] dur_reg, dur_next;
    logic [JOB_W-1:0] job_reg, job_next;

    // stored job is longer than the arriving one: it moves down a slot
    assign gt_out = valid_reg && (dur_reg > new_dur);

    always_comb begin
        valid_next = valid_reg;
        dur_next   = dur_reg;
        job_next   = job_reg;
        if (ctl.shift) begin
            valid_next = next_cell.valid;
            dur_next   = next_cell.dur;
            job_next   = next_cell.job;
        end else if (ctl.insert) begin
            if (prev_gt) begin
                valid_next = prev_cell.valid;
                dur_next   = prev_cell.dur;
                job_next   = prev_cell.job;
            end else if (gt_out || (!valid_reg && prev_cell.valid)) begin
                valid_next = 1'b1;
                dur_next   = new_dur;
                job_next   = new_job;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        dur_reg <= dur_next;
        job_reg <= job_next;
    end

    assign cell_out = '{valid: valid_reg, dur: dur_reg, job: job_reg};

endmodule

/* tb/tb.sv */
module tb
    import sjf_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // one expected or observed result, same fields as m_tdata/m_tuser/m_tlast
    typedef struct packed {
        logic [JOB_W-1:0] job;
        logic [DUR_W-1:0] dur;
        logic [FIN_W-1:0] fin;
        logic [SUM_W-1:0] total;
        logic             dropped;
        logic             eob;
    } sched_result_t;

    // Scoreboard: keeps its own sorted chain and queues the schedule of each closed batch.
    class sjf_scoreboard;
        logic [DUR_W-1:0] chain_dur [MAX_JOBS_DEF];
        logic [JOB_W-1:0] chain_job [MAX_JOBS_DEF];
        int               jobs_held;
        bit               over_capacity;
        sched_result_t    schedule_q[$];
        int               mismatches;
        int               results_seen;
        int               batches;
        int               full_batches;
        int               overflow_batches;

        function int pending();
            return schedule_q.size();
        endfunction

        // accepted job request: insert after every job with duration <= this one
        function void note_job(logic [DUR_W-1:0] dur, logic last);
            int               pos;
            int               i;
            logic [RUN_W-1:0] run;
            logic [SUM_W-1:0] sum;
            sched_result_t    r;
            if (jobs_held < MAX_JOBS_DEF) begin
                pos = jobs_held;
                while (pos > 0 && chain_dur[pos-1] > dur) begin
                    chain_dur[pos] = chain_dur[pos-1];
                    chain_job[pos] = chain_job[pos-1];
                    pos--;
                end
                chain_dur[pos] = dur;
                chain_job[pos] = JOB_W'(jobs_held + 1);
                jobs_held++;
            end else begin
                over_capacity = 1'b1;
            end
            if (!last) return;
            run = '0;
            sum = '0;
            for (i = 0; i < jobs_held; i++) begin
                run       = run + RUN_W'(chain_dur[i]);
                sum       = sum + SUM_W'(run);
                r.job     = chain_job[i];
                r.dur     = chain_dur[i];
                r.fin     = run[FIN_W-1:0];
                r.total   = (i == jobs_held - 1) ? sum : '0;
                r.dropped = over_capacity;
                r.eob     = (i == jobs_held - 1);
                schedule_q.push_back(r);
            end
            batches++;
            if (jobs_held == MAX_JOBS_DEF) full_batches++;
            if (over_capacity) overflow_batches++;
            jobs_held     = 0;
            over_capacity = 1'b0;
        endfunction

        function void check_result(logic [79:0] data, logic [0:0] user, logic last);
            sched_result_t got;
            sched_result_t want;
            got.job     = data[6:0];
            got.dur     = data[22:7];
            got.fin     = data[44:23];
            got.total   = data[72:45];
            got.dropped = user[0];
            got.eob     = last;
            results_seen++;
            if (schedule_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: job %0d dur %0d fin %0d total %0d",
                             $realtime, got.job, got.dur, got.fin, got.total);
                return;
            end
            want = schedule_q.pop_front();
            if (got.job !== want.job || got.dur !== want.dur || got.fin !== want.fin ||
                got.total !== want.total || got.dropped !== want.dropped ||
                got.eob !== want.eob) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] result mismatch #%0d", $realtime, mismatches);
                    $display("  exp: job %0d dur %0d fin %0d total %0d drop %0b last %0b",
                             want.job, want.dur, want.fin, want.total, want.dropped, want.eob);
                    $display("  got: job %0d dur %0d fin %0d total %0d drop %0b last %0b",
                             got.job, got.dur, got.fin, got.total, got.dropped, got.eob);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    sjf_scoreboard sb;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            rx_hold_left;
    int            jobs_sent;
    int            cycle_count;

    shortest_job_first_scheduler u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // receiver: long hold-off when requested, otherwise random stalls
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every accepted result goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // one job request; random idle cycles first, then hold until accepted
    task automatic send_job(logic [15:0] dur, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dur;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_job(dur, last);
        jobs_sent++;
    endtask

    function automatic logic [15:0] pick_duration();
        // bias toward ties and toward the top of the range
        case ($urandom_range(3))
            0:       return 16'($urandom_range(7));
            1:       return 16'hFFFF - 16'($urandom_range(3));
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic send_batch(int n, bit all_max);
        int i;
        for (i = 0; i < n; i++)
            send_job(all_max ? 16'hFFFF : pick_duration(), i == n - 1);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
    endtask

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        rx_hold_left = 0;
        jobs_sent    = 0;
        cycle_count  = 0;
        tx_idle_pct  = 13;
        rx_idle_pct  = 74;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one-job batches at both extremes
        send_job(16'h0000, 1'b1);
        send_job(16'hFFFF, 1'b1);
        // ties must keep arrival order
        send_job(16'd5, 1'b0);
        send_job(16'd3, 1'b0);
        send_job(16'd5, 1'b0);
        send_job(16'd0, 1'b0);
        send_job(16'd3, 1'b1);
        // alternating bit patterns
        send_job(16'hAAAA, 1'b0);
        send_job(16'h5555, 1'b0);
        send_job(16'hFFFF, 1'b0);
        send_job(16'h0000, 1'b1);
        // already sorted, reversed, all equal
        send_job(16'd1, 1'b0);
        send_job(16'd2, 1'b0);
        send_job(16'd3, 1'b1);
        send_job(16'd3, 1'b0);
        send_job(16'd2, 1'b0);
        send_job(16'd1, 1'b1);
        send_job(16'd7, 1'b0);
        send_job(16'd7, 1'b0);
        send_job(16'd7, 1'b1);

        // slow receiver
        while (jobs_sent < 110) send_batch($urandom_range(1, 8), 1'b0);
        // over capacity, all max: last two jobs dropped (the flagged one too),
        // largest finish times and total
        send_batch(MAX_JOBS_DEF + 2, 1'b1);
        drop_valid();
        while (sb.pending() != 0) @(posedge aclk);

        // slow sender
        tx_idle_pct = 74;
        rx_idle_pct = 13;
        while (jobs_sent < 250) send_batch($urandom_range(1, 8), 1'b0);

        // full speed; receiver frozen while a full batch goes in, next batch must stall
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left <= HOLD_CYCLES;
        send_batch(MAX_JOBS_DEF, 1'b0);
        send_batch(5, 1'b0);
        while (jobs_sent < 360) send_batch($urandom_range(1, 8), 1'b0);

        drop_valid();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d job requests in %0d batches (%0d full, %0d over capacity)",
                 jobs_sent, sb.batches, sb.full_batches, sb.overflow_batches);
        $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
